@@ hdl/vhu_pkg.sv @@
// Package for the Vicsek heading update block: constants, tables and shared types.
package vhu_pkg;

    localparam int MaxTermsDefault = 64;
    localparam int CordicSteps = 16;
    localparam int AngleW = 16;
    localparam int AccW = 23;
    localparam int QW = 16;
    localparam int CordW = 34;
    localparam int VecW = 33;
    localparam int ZW = 34;
    localparam int QueueDepth = 4;

    localparam logic signed [AccW-1:0] AccMax = 23'sd4194303;
    localparam logic signed [AccW-1:0] AccMin = -23'sd4194304;
    localparam logic signed [CordW-1:0] GainInv = 34'sd652032874;

    function automatic logic signed [ZW-1:0] arc(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                4'd0: r = 34'sd536870912;
                4'd1: r = 34'sd316933405;
                4'd2: r = 34'sd167458907;
                4'd3: r = 34'sd85004756;
                4'd4: r = 34'sd42667331;
                4'd5: r = 34'sd21354465;
                4'd6: r = 34'sd10679838;
                4'd7: r = 34'sd5340245;
                4'd8: r = 34'sd2670163;
                4'd9: r = 34'sd1335086;
                4'd10: r = 34'sd667544;
                4'd11: r = 34'sd333772;
                4'd12: r = 34'sd166886;
                4'd13: r = 34'sd83443;
                4'd14: r = 34'sd41721;
                default: r = 34'sd20860;
            endcase
            return r;
        end
    endfunction

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        logic signed [AccW-1:0] cos_sum;
        logic signed [AccW-1:0] sin_sum;
        logic [AngleW-1:0] rnd;
    } run_item_t;

endpackage

@@ hdl/vhu_sincos.sv @@
// Pipelined rotation-mode CORDIC producing Q1.15 cosine and sine of an angle.
module vhu_sincos
    import vhu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [AngleW-1:0]      angle,
    input  logic                   in_tag,
    input  logic [AngleW-1:0]      in_rnd,
    output logic                   out_valid,
    output logic                   out_tag,
    output logic [AngleW-1:0]      out_rnd,
    output logic signed [QW-1:0]   cos_q,
    output logic signed [QW-1:0]   sin_q
);
    logic signed [CordW-1:0] x_reg [CordicSteps+1];
    logic signed [CordW-1:0] y_reg [CordicSteps+1];
    logic signed [ZW-1:0]    z_reg [CordicSteps+1];
    logic [1:0]              q_reg [CordicSteps+1];
    logic                    v_reg [CordicSteps+1];
    logic                    t_reg [CordicSteps+1];
    logic [AngleW-1:0]       r_reg [CordicSteps+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= GainInv;
            y_reg[0] <= '0;
            z_reg[0] <= ZW'({angle[13:0], 16'd0});
            q_reg[0] <= angle[15:14];
            t_reg[0] <= in_tag;
            r_reg[0] <= in_rnd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CordicSteps; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= CordicSteps; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
        logic signed [CordW-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - arc(4'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + arc(4'(i));
                end
                q_reg[i+1] <= q_reg[i];
                t_reg[i+1] <= t_reg[i];
                r_reg[i+1] <= r_reg[i];
            end
        end
    end

    logic signed [CordW-1:0] xr, yr, xs, ys;
    always_comb begin
        xr = x_reg[CordicSteps];
        yr = y_reg[CordicSteps];
        case (q_reg[CordicSteps])
            2'd1: begin xs = -yr; ys = xr; end
            2'd2: begin xs = -xr; ys = -yr; end
            2'd3: begin xs = yr;  ys = -xr; end
            default: begin xs = xr; ys = yr; end
        endcase
    end

    function automatic logic signed [QW-1:0] to_q15(input logic signed [CordW-1:0] v);
        logic signed [CordW-1:0] r;
        begin
            r = (v + CordW'(16384)) >>> 15;
            if (r > CordW'(32767)) return 16'sh7FFF;
            if (r < -CordW'(32768)) return 16'sh8000;
            return r[QW-1:0];
        end
    endfunction

    assign cos_q = to_q15(xs);
    assign sin_q = to_q15(ys);
    assign out_valid = v_reg[CordicSteps];
    assign out_tag = t_reg[CordicSteps];
    assign out_rnd = r_reg[CordicSteps];
endmodule

@@ hdl/vhu_front.sv @@
// Front part: sine/cosine pipeline plus saturating accumulators, closes runs into the queue.
module vhu_front
    import vhu_pkg::*;
#(
    parameter int MAX_TERMS = MaxTermsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [AngleW-1:0] s_heading_angle,
    input  logic [AngleW-1:0] s_random_word,
    input  logic              s_last_term,
    input  logic              q_room,
    output logic              q_push,
    output run_item_t         q_data
);
    localparam int CntW = $clog2(MAX_TERMS + 1);

    logic [CntW-1:0] cnt_reg, cnt_next;
    logic signed [AccW-1:0] cs_reg, ss_reg, cs_next, ss_next;
    logic en, acc_ok, take;
    logic pv, pt;
    logic [AngleW-1:0] pr;
    logic signed [QW-1:0] c, s;

    // The pipeline only advances when the queue can absorb whatever leaves it.
    assign en = q_room;
    assign s_ready = en;
    assign take = s_valid && s_ready;
    assign acc_ok = cnt_reg < CntW'(MAX_TERMS);

    // Terms past the limit enter with the accumulate flag cleared; the flag
    // travels in a shift register beside the pipeline.
    logic tag_in;
    logic lim_in;
    assign lim_in = acc_ok;
    assign tag_in = s_last_term;

    logic [CordicSteps:0] lim_sr;
    vhu_sincos u_sc (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(take),
        .angle(s_heading_angle), .in_tag(tag_in), .in_rnd(s_random_word),
        .out_valid(pv), .out_tag(pt), .out_rnd(pr), .cos_q(c), .sin_q(s)
    );

    always_ff @(posedge aclk) begin
        if (en) lim_sr <= {lim_sr[CordicSteps-1:0], lim_in};
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (take) cnt_next = s_last_term ? '0 : (acc_ok ? cnt_reg + 1'b1 : cnt_reg);
    end

    function automatic logic signed [AccW-1:0] sat(input logic signed [AccW-1:0] a,
                                                   input logic signed [QW-1:0] b);
        logic signed [AccW:0] r;
        begin
            r = (AccW+1)'(a) + (AccW+1)'(b);
            if (r > (AccW+1)'(AccMax)) return AccMax;
            if (r < (AccW+1)'(AccMin)) return AccMin;
            return r[AccW-1:0];
        end
    endfunction

    logic signed [AccW-1:0] cs_new, ss_new;
    always_comb begin
        cs_new = lim_sr[CordicSteps] ? sat(cs_reg, c) : cs_reg;
        ss_new = lim_sr[CordicSteps] ? sat(ss_reg, s) : ss_reg;
        cs_next = cs_reg;
        ss_next = ss_reg;
        if (en && pv) begin
            cs_next = pt ? '0 : cs_new;
            ss_next = pt ? '0 : ss_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            cs_reg <= '0;
            ss_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            cs_reg <= cs_next;
            ss_reg <= ss_next;
        end
    end

    assign q_push = en && pv && pt;
    assign q_data = '{cos_sum: cs_new, sin_sum: ss_new, rnd: pr};
endmodule

@@ hdl/vhu_queue.sv @@
// Small FIFO between the front and back parts.
module vhu_queue
    import vhu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  run_item_t push_data,
    output logic      room,
    output logic      pop_valid,
    input  logic      pop,
    output run_item_t pop_data
);
    localparam int AW = $clog2(QueueDepth);
    run_item_t mem [QueueDepth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] n_reg;

    // Room is signalled only while fewer than QueueDepth - 1 items are held; without it the front pipeline stalls.
    assign room = n_reg < (AW+1)'(QueueDepth - 1);
    assign pop_valid = n_reg != '0;
    assign pop_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop && pop_valid) rp_reg <= rp_reg + 1'b1;
            n_reg <= n_reg + (AW+1)'(push) - (AW+1)'(pop && pop_valid);
        end
    end
endmodule

@@ hdl/vhu_back.sv @@
// Back part: iterative vectoring CORDIC for the mean angle, noise add, output register.
module vhu_back
    import vhu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [AngleW-1:0] noise_amp,
    input  logic              q_valid,
    output logic              q_pop,
    input  run_item_t         q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [AngleW-1:0] m_new_heading
);
    logic busy_reg;
    logic [4:0] step_reg;
    logic signed [VecW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic zero_reg;
    logic signed [33:0] noise_reg;
    logic ov_reg;
    logic [AngleW-1:0] od_reg;

    logic done;
    assign done = busy_reg && step_reg == 5'(CordicSteps);
    assign q_pop = q_valid && !busy_reg;

    logic signed [VecW-1:0] xi, yi, dx, dy;
    assign xi = VecW'(q_data.cos_sum) <<< 8;
    assign yi = VecW'(q_data.sin_sum) <<< 8;
    assign dx = y_reg >>> step_reg[3:0];
    assign dy = x_reg >>> step_reg[3:0];

    logic signed [33:0] prod;
    assign prod = ($signed({1'b0, q_data.rnd}) - 34'sd32768) * $signed({18'd0, noise_amp});

    logic signed [ZW-1:0] zr;
    logic [AngleW-1:0] mean, noise;
    always_comb begin
        zr = z_reg + ZW'(32768);
        mean = zero_reg ? '0 : zr[31:16];
        noise = noise_reg[31:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (done && (!ov_reg || m_ready)) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && !done) begin
                step_reg <= step_reg + 1'b1;
            end
            if (done && (!ov_reg || m_ready)) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            zero_reg <= q_data.cos_sum == '0 && q_data.sin_sum == '0;
            noise_reg <= prod;
            if (xi[VecW-1]) begin
                x_reg <= -xi;
                y_reg <= -yi;
                z_reg <= 34'sd2147483648;
            end else begin
                x_reg <= xi;
                y_reg <= yi;
                z_reg <= '0;
            end
        end else if (busy_reg && !done) begin
            if (y_reg[VecW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - arc(step_reg[3:0]);
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + arc(step_reg[3:0]);
            end
        end
        if (done && (!ov_reg || m_ready)) od_reg <= mean + noise;
    end

    assign m_valid = ov_reg;
    assign m_new_heading = od_reg;
endmodule

@@ hdl/vicsek_heading_update_top.sv @@
// Top level of the Vicsek heading update block.
// Input channel s_*: one heading per item, own heading first, neighbors after,
// s_last_term on the final item of a particle's run. Items are taken one per
// cycle while the internal queue has room; the 16-stage sine/cosine pipeline
// feeds saturating accumulators. Only the first MAX_TERMS items of a run
// are summed. Each closed run enters a short queue; the back part runs a
// 16-step vectoring CORDIC on one shared unit, so it takes a new run from
// the queue only once it is idle, after the previous result has moved into
// the output register.
// m_new_heading is held in an output register until m_ready; while the
// receiver stalls the queue fills and s_ready drops.
// The cfg channel writes noise_amplitude; it is always ready.
// Synchronous active-low reset clears the sums, counters, queue and amplitude.
module vicsek_heading_update_top
    import vhu_pkg::*;
#(
    parameter int MAX_TERMS = MaxTermsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [AngleW-1:0] s_heading_angle,
    input  logic [AngleW-1:0] s_random_word,
    input  logic              s_last_term,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [AngleW-1:0] m_new_heading
);
    logic [AngleW-1:0] amp_reg;
    logic room, push, qv, pop;
    run_item_t pd, qd;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) amp_reg <= '0;
        else if (cfg_valid) amp_reg <= cfg_data;
    end

    vhu_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_heading_angle(s_heading_angle), .s_random_word(s_random_word),
        .s_last_term(s_last_term), .q_room(room), .q_push(push), .q_data(pd)
    );

    vhu_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_data(pd), .room(room),
        .pop_valid(qv), .pop(pop), .pop_data(qd)
    );

    vhu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .noise_amp(amp_reg), .q_valid(qv),
        .q_pop(pop), .q_data(qd), .m_valid(m_valid), .m_ready(m_ready),
        .m_new_heading(m_new_heading)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_heading))
        else $error("result changed while stalled");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("queue push without room");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == room)
        else $error("input ready does not follow queue room");
endmodule
